>>> hdl/cell_temperature_statistics_unit_macros.svh
// ----------------------------------------------------------------------------
// Cell temperature statistics unit - assertion macros
// Concurrent checks clocked on clk_i, held off while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef CELL_TEMPERATURE_STATISTICS_UNIT_MACROS_SVH
`define CELL_TEMPERATURE_STATISTICS_UNIT_MACROS_SVH

// same-cycle implication
`define CTSU_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define CTSU_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hdl/ctsu_pkg.sv
// ----------------------------------------------------------------------------
// ctsu_pkg
// Shared widths and the command / status groups between control and datapath.
// ----------------------------------------------------------------------------
package ctsu_pkg;

  localparam int unsigned TEMP_W = 16;
  localparam int unsigned IDX_W  = 8;
  localparam int unsigned SUM_W  = 24;
  localparam int unsigned MSUM_W = 48;
  localparam int unsigned CNT_W  = 32;
  localparam int unsigned DVD_W  = 48;
  localparam int unsigned STEP_W = 6;

  localparam logic [STEP_W-1:0] STEPS_AVG  = STEP_W'(SUM_W);
  localparam logic [STEP_W-1:0] STEPS_SESS = STEP_W'(MSUM_W);

  typedef struct packed {
    logic take;
    logic start_avg;
    logic latch_avg;
    logic start_sess;
    logic latch_sess;
    logic load_out;
  } ctsu_cmd_t;

  typedef struct packed {
    logic last;
    logic div_done;
  } ctsu_sts_t;

endpackage

>>> hdl/cell_temperature_statistics_unit.sv
// A reading that does not close a sample is taken without stalling the input.
// A reading that closes a sample stalls the input until its result is loaded,
// which waits while the previous result is still stalled: 24 divider steps
// for the sample mean, 48 for the session mean, and handoff states on the one divider.
// The result is registered and becomes valid when the sequencer loads it.
// Reset (rst_ni low, async) clears running/session state; cell_count is 1.
// ----------------------------------------------------------------------------
// cell_temperature_statistics_unit
// Per-sample max/min/mean/spread of cell temperatures with session tracking.
// ----------------------------------------------------------------------------
`include "cell_temperature_statistics_unit_macros.svh"

module cell_temperature_statistics_unit (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // configuration
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [2:0]                          paddr,
  input  logic [31:0]                         pwdata,
  output logic [31:0]                         prdata,
  output logic                                pready,
  // readings
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic signed [ctsu_pkg::TEMP_W-1:0]  cell_temp_i,
  // results
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic signed [ctsu_pkg::TEMP_W-1:0]  max_temp_o,
  output logic signed [ctsu_pkg::TEMP_W-1:0]  min_temp_o,
  output logic signed [ctsu_pkg::TEMP_W-1:0]  avg_temp_o,
  output logic signed [ctsu_pkg::TEMP_W-1:0]  temp_spread_o,
  output logic [ctsu_pkg::IDX_W-1:0]          hottest_cell_o,
  output logic [ctsu_pkg::IDX_W-1:0]          coldest_cell_o,
  output logic signed [ctsu_pkg::TEMP_W-1:0]  session_max_temp_o,
  output logic signed [ctsu_pkg::TEMP_W-1:0]  session_max_spread_o,
  output logic signed [ctsu_pkg::TEMP_W-1:0]  session_avg_temp_o
);

  localparam logic REG_CELL_COUNT = 1'b0;

  logic [ctsu_pkg::IDX_W-1:0] cell_count_q, cell_count_d;
  logic                       cfg_wr;
  ctsu_pkg::ctsu_cmd_t        cmd;
  ctsu_pkg::ctsu_sts_t        sts;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready;

  always_comb begin
    cell_count_d = cell_count_q;
    if (cfg_wr && (paddr[2] == REG_CELL_COUNT)) begin
      cell_count_d = pwdata[ctsu_pkg::IDX_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cell_count_q <= ctsu_pkg::IDX_W'(1);
    end else begin
      cell_count_q <= cell_count_d;
    end
  end

  assign prdata = (paddr[2] == REG_CELL_COUNT) ? {{(32-ctsu_pkg::IDX_W){1'b0}}, cell_count_q}
                                               : 32'd0;

  ctsu_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  ctsu_dp u_dp (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .cmd_i                (cmd),
    .sts_o                (sts),
    .cell_count_i         (cell_count_q),
    .cell_temp_i          (cell_temp_i),
    .max_temp_o           (max_temp_o),
    .min_temp_o           (min_temp_o),
    .avg_temp_o           (avg_temp_o),
    .temp_spread_o        (temp_spread_o),
    .hottest_cell_o       (hottest_cell_o),
    .coldest_cell_o       (coldest_cell_o),
    .session_max_temp_o   (session_max_temp_o),
    .session_max_spread_o (session_max_spread_o),
    .session_avg_temp_o   (session_avg_temp_o)
  );

  `CTSU_ASSERT_NXT(a_close_stalls, in_valid_i && !in_stall_o && sts.last, in_stall_o, "no stall")
  `CTSU_ASSERT_IMP(a_div_busy, sts.div_done, in_stall_o, "divider finished while input open")
  `CTSU_ASSERT_IMP(a_no_overwrite, cmd.load_out, !(out_valid_o && out_stall_i), "overwrite")
  `CTSU_ASSERT_NXT(a_load_valid, cmd.load_out, out_valid_o, "loaded result not valid")

endmodule

>>> hdl/ctsu_div.sv
// ----------------------------------------------------------------------------
// ctsu_div
// Restoring divider, one quotient bit per cycle, signed result truncated
// toward zero and cut to 16 bits.
// ----------------------------------------------------------------------------
module ctsu_div (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  input  logic                                neg_i,
  input  logic [ctsu_pkg::DVD_W-1:0]          dividend_i,
  input  logic [ctsu_pkg::CNT_W-1:0]          divisor_i,
  input  logic [ctsu_pkg::STEP_W-1:0]         steps_i,
  output logic                                done_o,
  output logic signed [ctsu_pkg::TEMP_W-1:0]  quot_o
);

  localparam logic [ctsu_pkg::STEP_W-1:0] STEP_ONE = ctsu_pkg::STEP_W'(1);

  logic                          busy_q, busy_d;
  logic                          done_q, done_d;
  logic [ctsu_pkg::STEP_W-1:0]   cnt_q, cnt_d;
  logic                          neg_q, neg_d;
  logic [ctsu_pkg::DVD_W-1:0]    dvd_q, dvd_d;
  logic [ctsu_pkg::CNT_W-1:0]    rem_q, rem_d;
  logic [ctsu_pkg::CNT_W-1:0]    dsr_q, dsr_d;
  logic [ctsu_pkg::CNT_W:0]      shifted;
  logic [ctsu_pkg::CNT_W+1:0]    diff;

  assign shifted = {rem_q, dvd_q[ctsu_pkg::DVD_W-1]};
  assign diff    = {1'b0, shifted} - {2'b00, dsr_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    neg_d  = neg_q;
    dvd_d  = dvd_q;
    rem_d  = rem_q;
    dsr_d  = dsr_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = steps_i;
      neg_d  = neg_i;
      dvd_d  = dividend_i;
      rem_d  = '0;
      dsr_d  = divisor_i;
    end else if (busy_q) begin
      if (diff[ctsu_pkg::CNT_W+1]) begin
        rem_d = shifted[ctsu_pkg::CNT_W-1:0];
        dvd_d = {dvd_q[ctsu_pkg::DVD_W-2:0], 1'b0};
      end else begin
        rem_d = diff[ctsu_pkg::CNT_W-1:0];
        dvd_d = {dvd_q[ctsu_pkg::DVD_W-2:0], 1'b1};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == STEP_ONE) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    neg_q <= neg_d;
    dvd_q <= dvd_d;
    rem_q <= rem_d;
    dsr_q <= dsr_d;
  end

  assign done_o = done_q;
  assign quot_o = neg_q ? ctsu_pkg::TEMP_W'(16'd0 - dvd_q[ctsu_pkg::TEMP_W-1:0])
                        : dvd_q[ctsu_pkg::TEMP_W-1:0];

endmodule

>>> hdl/ctsu_dp.sv
// ----------------------------------------------------------------------------
// ctsu_dp
// Datapath: per-sample running max/min/sum, session tracking, shared divider
// and the result registers.
// ----------------------------------------------------------------------------
module ctsu_dp (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  ctsu_pkg::ctsu_cmd_t                 cmd_i,
  output ctsu_pkg::ctsu_sts_t                 sts_o,
  input  logic [ctsu_pkg::IDX_W-1:0]          cell_count_i,
  input  logic signed [ctsu_pkg::TEMP_W-1:0]  cell_temp_i,
  output logic signed [ctsu_pkg::TEMP_W-1:0]  max_temp_o,
  output logic signed [ctsu_pkg::TEMP_W-1:0]  min_temp_o,
  output logic signed [ctsu_pkg::TEMP_W-1:0]  avg_temp_o,
  output logic signed [ctsu_pkg::TEMP_W-1:0]  temp_spread_o,
  output logic [ctsu_pkg::IDX_W-1:0]          hottest_cell_o,
  output logic [ctsu_pkg::IDX_W-1:0]          coldest_cell_o,
  output logic signed [ctsu_pkg::TEMP_W-1:0]  session_max_temp_o,
  output logic signed [ctsu_pkg::TEMP_W-1:0]  session_max_spread_o,
  output logic signed [ctsu_pkg::TEMP_W-1:0]  session_avg_temp_o
);

  // per-sample accumulation
  logic [ctsu_pkg::IDX_W-1:0]         cell_index_q, cell_index_d;
  logic signed [ctsu_pkg::TEMP_W-1:0] run_max_q, run_max_d;
  logic signed [ctsu_pkg::TEMP_W-1:0] run_min_q, run_min_d;
  logic [ctsu_pkg::IDX_W-1:0]         max_idx_q, max_idx_d;
  logic [ctsu_pkg::IDX_W-1:0]         min_idx_q, min_idx_d;
  logic signed [ctsu_pkg::SUM_W-1:0]  run_sum_q, run_sum_d;
  // session state
  logic                               primed_q, primed_d;
  logic signed [ctsu_pkg::TEMP_W-1:0] worst_temp_q, worst_temp_d;
  logic signed [ctsu_pkg::TEMP_W-1:0] worst_spread_q, worst_spread_d;
  logic signed [ctsu_pkg::MSUM_W-1:0] mean_sum_q, mean_sum_d;
  logic [ctsu_pkg::CNT_W-1:0]         sample_count_q, sample_count_d;
  // finished sample, waiting for the divider
  logic signed [ctsu_pkg::TEMP_W-1:0] s_max_q, s_min_q, s_spread_q, s_avg_q, s_sess_q;
  logic [ctsu_pkg::IDX_W-1:0]         s_max_idx_q, s_min_idx_q;

  logic                               first;
  logic signed [ctsu_pkg::TEMP_W-1:0] nmax, nmin, nspread;
  logic [ctsu_pkg::IDX_W-1:0]         nmax_idx, nmin_idx;
  logic signed [ctsu_pkg::SUM_W-1:0]  nsum;
  logic [ctsu_pkg::SUM_W-1:0]         nsum_abs;
  logic [ctsu_pkg::IDX_W:0]           taken;
  logic [ctsu_pkg::MSUM_W-1:0]        msum_abs;

  logic                               div_start, div_neg, div_done;
  logic [ctsu_pkg::DVD_W-1:0]         div_dvd;
  logic [ctsu_pkg::CNT_W-1:0]         div_dsr;
  logic [ctsu_pkg::STEP_W-1:0]        div_steps;
  logic signed [ctsu_pkg::TEMP_W-1:0] div_quot;

  assign first = (cell_index_q == '0);
  assign taken = {1'b0, cell_index_q} + 1'b1;
  assign nsum  = run_sum_q + ctsu_pkg::SUM_W'(cell_temp_i);

  always_comb begin
    nmax     = run_max_q;
    nmax_idx = max_idx_q;
    nmin     = run_min_q;
    nmin_idx = min_idx_q;
    if (first) begin
      nmax     = cell_temp_i;
      nmin     = cell_temp_i;
      nmax_idx = '0;
      nmin_idx = '0;
    end else begin
      if (cell_temp_i > run_max_q) begin
        nmax     = cell_temp_i;
        nmax_idx = cell_index_q;
      end
      if (cell_temp_i < run_min_q) begin
        nmin     = cell_temp_i;
        nmin_idx = cell_index_q;
      end
    end
  end

  assign nspread  = nmax - nmin;
  assign nsum_abs = nsum[ctsu_pkg::SUM_W-1] ? ctsu_pkg::SUM_W'(-nsum) : nsum;
  assign msum_abs = mean_sum_q[ctsu_pkg::MSUM_W-1] ? ctsu_pkg::MSUM_W'(-mean_sum_q)
                                                   : mean_sum_q;

  assign sts_o.last     = (taken >= {1'b0, cell_count_i});
  assign sts_o.div_done = div_done;

  always_comb begin
    cell_index_d   = cell_index_q;
    run_max_d      = run_max_q;
    run_min_d      = run_min_q;
    max_idx_d      = max_idx_q;
    min_idx_d      = min_idx_q;
    run_sum_d      = run_sum_q;
    primed_d       = primed_q;
    worst_temp_d   = worst_temp_q;
    worst_spread_d = worst_spread_q;
    mean_sum_d     = mean_sum_q;
    sample_count_d = sample_count_q;
    if (cmd_i.take) begin
      if (sts_o.last) begin
        cell_index_d = '0;
        run_max_d    = '0;
        run_min_d    = '0;
        max_idx_d    = '0;
        min_idx_d    = '0;
        run_sum_d    = '0;
        primed_d     = 1'b1;
        if (!primed_q || (nmax > worst_temp_q)) begin
          worst_temp_d = nmax;
        end
        if (!primed_q || (nspread > worst_spread_q)) begin
          worst_spread_d = nspread;
        end
      end else begin
        cell_index_d = taken[ctsu_pkg::IDX_W-1:0];
        run_max_d    = nmax;
        run_min_d    = nmin;
        max_idx_d    = nmax_idx;
        min_idx_d    = nmin_idx;
        run_sum_d    = nsum;
      end
    end
    if (cmd_i.latch_avg && (sample_count_q != {ctsu_pkg::CNT_W{1'b1}})) begin
      mean_sum_d     = mean_sum_q + ctsu_pkg::MSUM_W'(div_quot);
      sample_count_d = sample_count_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cell_index_q   <= '0;
      run_max_q      <= '0;
      run_min_q      <= '0;
      max_idx_q      <= '0;
      min_idx_q      <= '0;
      run_sum_q      <= '0;
      primed_q       <= 1'b0;
      worst_temp_q   <= '0;
      worst_spread_q <= '0;
      mean_sum_q     <= '0;
      sample_count_q <= '0;
    end else begin
      cell_index_q   <= cell_index_d;
      run_max_q      <= run_max_d;
      run_min_q      <= run_min_d;
      max_idx_q      <= max_idx_d;
      min_idx_q      <= min_idx_d;
      run_sum_q      <= run_sum_d;
      primed_q       <= primed_d;
      worst_temp_q   <= worst_temp_d;
      worst_spread_q <= worst_spread_d;
      mean_sum_q     <= mean_sum_d;
      sample_count_q <= sample_count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.take && sts_o.last) begin
      s_max_q     <= nmax;
      s_min_q     <= nmin;
      s_max_idx_q <= nmax_idx;
      s_min_idx_q <= nmin_idx;
      s_spread_q  <= nspread;
    end
    if (cmd_i.latch_avg) begin
      s_avg_q <= div_quot;
    end
    if (cmd_i.latch_sess) begin
      s_sess_q <= div_quot;
    end
    if (cmd_i.load_out) begin
      max_temp_o           <= s_max_q;
      min_temp_o           <= s_min_q;
      avg_temp_o           <= s_avg_q;
      temp_spread_o        <= s_spread_q;
      hottest_cell_o       <= s_max_idx_q;
      coldest_cell_o       <= s_min_idx_q;
      session_max_temp_o   <= worst_temp_q;
      session_max_spread_o <= worst_spread_q;
      session_avg_temp_o   <= s_sess_q;
    end
  end

  // sample mean: |sum| placed in the upper half, 24 steps; session mean: |mean sum|, 48 steps
  always_comb begin
    div_start = cmd_i.start_avg | cmd_i.start_sess;
    if (cmd_i.start_sess) begin
      div_neg   = mean_sum_q[ctsu_pkg::MSUM_W-1];
      div_dvd   = msum_abs;
      div_dsr   = sample_count_q;
      div_steps = ctsu_pkg::STEPS_SESS;
    end else begin
      div_neg   = nsum[ctsu_pkg::SUM_W-1];
      div_dvd   = {nsum_abs, {(ctsu_pkg::DVD_W-ctsu_pkg::SUM_W){1'b0}}};
      div_dsr   = ctsu_pkg::CNT_W'(taken);
      div_steps = ctsu_pkg::STEPS_AVG;
    end
  end

  ctsu_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .neg_i      (div_neg),
    .dividend_i (div_dvd),
    .divisor_i  (div_dsr),
    .steps_i    (div_steps),
    .done_o     (div_done),
    .quot_o     (div_quot)
  );

endmodule

>>> hdl/ctsu_ctrl.sv
// ----------------------------------------------------------------------------
// ctsu_ctrl
// Sequencer: takes readings, runs the two divisions of a finished sample and
// hands the result to the output register.
// ----------------------------------------------------------------------------
module ctsu_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  input  ctsu_pkg::ctsu_sts_t  sts_i,
  output ctsu_pkg::ctsu_cmd_t  cmd_o
);

  localparam logic [2:0] ST_IDLE     = 3'd0;
  localparam logic [2:0] ST_DIV_AVG  = 3'd1;
  localparam logic [2:0] ST_SESS_GO  = 3'd2;
  localparam logic [2:0] ST_DIV_SESS = 3'd3;
  localparam logic [2:0] ST_LOAD     = 3'd4;

  logic [2:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.take = 1'b1;
          if (sts_i.last) begin
            cmd_o.start_avg = 1'b1;
            state_d         = ST_DIV_AVG;
          end
        end
      end
      ST_DIV_AVG: begin
        if (sts_i.div_done) begin
          cmd_o.latch_avg = 1'b1;
          state_d         = ST_SESS_GO;
        end
      end
      ST_SESS_GO: begin
        cmd_o.start_sess = 1'b1;
        state_d          = ST_DIV_SESS;
      end
      ST_DIV_SESS: begin
        if (sts_i.div_done) begin
          cmd_o.latch_sess = 1'b1;
          state_d          = ST_LOAD;
        end
      end
      ST_LOAD: begin
        if (!out_valid_q || !out_stall_i) begin
          cmd_o.load_out = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.load_out) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule
